// ===== hdl/sgcd_pkg.sv =====
// ----------------------------------------------------------------------------
// sgcd_pkg
// Shared sizes for the pipelined binary gcd: operand width, port width,
// number of reduction stages and the resulting latency.
// ----------------------------------------------------------------------------
`default_nettype none

package sgcd_pkg;

  // port width of the operand and result fields
  localparam int unsigned FIELD_W = 32;

  // width of the arithmetic; operands are taken modulo 2**WIDTH
  localparam int unsigned WIDTH = 32;

  // width of the common power-of-two count
  localparam int unsigned SHIFT_W = $clog2(WIDTH);

  // each reduction step removes at least one bit from the sum of the
  // operand lengths, so 2*WIDTH steps always reach equal operands
  localparam int unsigned NSTEPS = 2 * WIDTH;

  // input register, NSTEPS reduction stages, output register
  localparam int unsigned LATENCY = NSTEPS + 2;

endpackage

`default_nettype wire

// ===== hdl/subtractive_gcd.sv =====
// ----------------------------------------------------------------------------
// subtractive_gcd
// Greatest common divisor of two unsigned operands, computed by a fully
// pipelined binary (Stein) gcd with one reduction step per stage.
// ----------------------------------------------------------------------------
// an accepted pair passes through the input register, the reduction stages and the output
//   register, where divisor is registered together with done
// throughput: one item per cycle; busy is low except while rst is held
// the depth is set by the worst-case count of binary gcd steps, one per stage
// reset clears every stage valid bit and done; items in flight are dropped
// results cannot be held off: done marks divisor for exactly one cycle
`default_nettype none

module subtractive_gcd (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [sgcd_pkg::FIELD_W-1:0] first_operand,
  input  wire logic [sgcd_pkg::FIELD_W-1:0] second_operand,
  output logic                              done,
  output logic [sgcd_pkg::FIELD_W-1:0]      divisor
);

  // per-stage state: operands, common power of two, finished flag, valid
  logic [sgcd_pkg::WIDTH-1:0]   opa [0:sgcd_pkg::NSTEPS];
  logic [sgcd_pkg::WIDTH-1:0]   opb [0:sgcd_pkg::NSTEPS];
  logic [sgcd_pkg::SHIFT_W-1:0] sh  [0:sgcd_pkg::NSTEPS];
  logic                         fin [0:sgcd_pkg::NSTEPS];
  logic                         vld [0:sgcd_pkg::NSTEPS];

  logic [sgcd_pkg::WIDTH-1:0] in_a;
  logic [sgcd_pkg::WIDTH-1:0] in_b;
  logic                       accept;

  // no stall anywhere downstream, so the only time an item is refused
  // is while the pipeline is being reset
  assign busy   = rst;
  assign accept = start && !busy;

  // operands reduced to the arithmetic width
  assign in_a = sgcd_pkg::WIDTH'(first_operand);
  assign in_b = sgcd_pkg::WIDTH'(second_operand);

  // entry stage: a zero operand finishes at once with the other operand
  // as the answer (both zero gives zero)
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
    if (in_a == '0 || in_b == '0) begin
      opa[0] <= in_a | in_b;
      fin[0] <= 1'b1;
    end else begin
      opa[0] <= in_a;
      fin[0] <= 1'b0;
    end
    opb[0] <= in_b;
    sh[0]  <= '0;
  end

  // reduction stages, one binary gcd step each:
  //   both even      -> halve both, count a common factor of two
  //   one even       -> halve that one
  //   both odd, equal -> finished, the gcd is opa << sh
  //   both odd       -> larger becomes (larger - smaller) / 2
  for (genvar i = 1; i <= sgcd_pkg::NSTEPS; i++) begin : g_step
    logic [sgcd_pkg::WIDTH-1:0]   a_next;
    logic [sgcd_pkg::WIDTH-1:0]   b_next;
    logic [sgcd_pkg::SHIFT_W-1:0] sh_next;
    logic                         fin_next;
    logic [sgcd_pkg::WIDTH:0]     diff;
    logic [sgcd_pkg::WIDTH-1:0]   mag;

    // one subtract; the borrow says which operand is larger
    assign diff = {1'b0, opa[i-1]} - {1'b0, opb[i-1]};
    assign mag  = diff[sgcd_pkg::WIDTH] ? (~diff[sgcd_pkg::WIDTH-1:0] + 1'b1)
                                        : diff[sgcd_pkg::WIDTH-1:0];

    always_comb begin
      a_next   = opa[i-1];
      b_next   = opb[i-1];
      sh_next  = sh[i-1];
      fin_next = fin[i-1];
      if (!fin[i-1]) begin
        if (!opa[i-1][0] && !opb[i-1][0]) begin
          a_next  = opa[i-1] >> 1;
          b_next  = opb[i-1] >> 1;
          sh_next = sh[i-1] + 1'b1;
        end else if (!opa[i-1][0]) begin
          a_next = opa[i-1] >> 1;
        end else if (!opb[i-1][0]) begin
          b_next = opb[i-1] >> 1;
        end else if (diff == '0) begin
          fin_next = 1'b1;
        end else if (diff[sgcd_pkg::WIDTH]) begin
          b_next = mag >> 1;
        end else begin
          a_next = mag >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else begin
        vld[i] <= vld[i-1];
      end
      opa[i] <= a_next;
      opb[i] <= b_next;
      sh[i]  <= sh_next;
      fin[i] <= fin_next;
    end
  end

  // output stage: restore the common power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[sgcd_pkg::NSTEPS];
    end
    divisor <= sgcd_pkg::FIELD_W'(opa[sgcd_pkg::NSTEPS] << sh[sgcd_pkg::NSTEPS]);
  end

`ifndef SYNTHESIS
  // the step bound must have finished every item by the last stage
  a_finished : assert property (@(posedge clk) disable iff (rst)
    vld[sgcd_pkg::NSTEPS] |-> fin[sgcd_pkg::NSTEPS])
    else $error("item reached the last stage unfinished");

  // a result only follows an item leaving the last stage
  a_done_src : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(vld[sgcd_pkg::NSTEPS]))
    else $error("done without an item in the last stage");

  // an item in the input register always reaches done, unless a reset drops it
  a_latency : assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> ##(sgcd_pkg::NSTEPS + 1) (done || $past(rst, sgcd_pkg::NSTEPS)))
    else $error("item lost in the pipeline");
`endif

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for subtractive_gcd. Operand pairs go in through the
// start/busy handshake and each divisor is checked against a binary gcd
// worked out here, in the order the pairs were accepted. Covers zero and
// equal operands, full-scale and sign-bit values, long coprime runs, then
// random pairs with built-in common factors, with random gaps and bursts.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned FIELD_W    = sgcd_pkg::FIELD_W;
  localparam int unsigned WIDTH      = sgcd_pkg::WIDTH;
  localparam int unsigned LATENCY    = sgcd_pkg::LATENCY;
  localparam int unsigned CLK_HALF   = 6;
  localparam int unsigned RAND_ITEMS = 700;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [FIELD_W-1:0] first_operand;
  logic [FIELD_W-1:0] second_operand;
  logic               done;
  logic [FIELD_W-1:0] divisor;

  // divisors still owed by the block, oldest first
  logic [FIELD_W-1:0] pending_divisors[$];

  int unsigned error_count;
  bit          burst_mode;   // when set the sender never idles between items

  subtractive_gcd u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .done           (done),
    .divisor        (divisor)
  );

  always #(CLK_HALF) clk = ~clk;

  // binary gcd at the block's arithmetic width
  function automatic logic [FIELD_W-1:0] stein_gcd(input logic [FIELD_W-1:0] a,
                                                   input logic [FIELD_W-1:0] b);
    logic [63:0] operand_mask;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] t;
    int unsigned shift;
    operand_mask = (WIDTH >= 64) ? {64{1'b1}} : ((64'd1 << WIDTH) - 64'd1);
    x = 64'(a) & operand_mask;
    y = 64'(b) & operand_mask;
    shift = 0;
    // either operand zero gives the other one back
    if (x == 64'd0) return FIELD_W'(y);
    if (y == 64'd0) return FIELD_W'(x);
    // pull out the common power of two
    while (((x | y) & 64'd1) == 64'd0) begin
      x = x >> 1;
      y = y >> 1;
      shift++;
    end
    while ((x & 64'd1) == 64'd0) x = x >> 1;
    // x odd from here on
    while (y != 64'd0) begin
      while ((y & 64'd1) == 64'd0) y = y >> 1;
      if (x > y) begin
        t = x;
        x = y;
        y = t;
      end
      y = y - x;
    end
    return FIELD_W'(x << shift);
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    error_count++;
  endtask

  // drives one item at the falling edge and waits for the accepting edge;
  // start stays high across back-to-back items without dropping in between
  task automatic send_item(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start          <= 1'b1;
    first_operand  <= a;
    second_operand <= b;
    // accepted at the first rising edge with busy low
    do @(posedge clk); while (busy !== 1'b0);
    pending_divisors.push_back(stein_gcd(a, b));
  endtask

  task automatic release_start();
    @(negedge clk);
    start <= 1'b0;
  endtask

  // hold the sender off until the pipeline has handed back everything
  task automatic wait_for_drain();
    release_start();
    while (pending_divisors.size() != 0) @(posedge clk);
  endtask

  // zeros, equal operands, full scale, sign bit, powers of two, long chains
  task automatic test_edge_operands();
    burst_mode = 1'b0;
    send_item('0, '0);
    send_item('0, 32'd1);
    send_item(32'd1, '0);
    send_item('0, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFF, '0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(32'd1, 32'd1);
    send_item(32'd12345, 32'd12345);
    send_item(32'h8000_0000, 32'h8000_0000);
    send_item(32'h8000_0000, 32'h4000_0000);
    send_item(32'h8000_0000, 32'hFFFF_FFFF);
    send_item(32'hFFFF_FFFE, 32'h8000_0002);
    send_item(32'hFFFF_FFFF, 32'd1);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_item(32'd1, 32'h8000_0000);
    // neighboring fibonacci numbers, the longest subtractive chain in range
    send_item(32'd2971215073, 32'd1836311903);
    send_item(32'd1836311903, 32'd2971215073);
    send_item(32'd4294967291, 32'd4294967279);
    send_item(32'hAAAA_AAAA, 32'h5555_5555);
    send_item(32'd48, 32'd18);
    send_item(32'd18, 32'd48);
    // back-to-back stretch
    burst_mode = 1'b1;
    send_item(32'd1024, 32'd768);
    send_item(32'h7FFF_FFFF, 32'h8000_0001);
    send_item(32'd3, 32'd7);
    burst_mode = 1'b0;
  endtask

  // random pairs, mostly with structure so that the divisor is not always 1
  task automatic test_random_operands(input int unsigned count);
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] factor;
    int unsigned        sel;
    for (int unsigned i = 0; i < count; i++) begin
      // switch between bursts and idle gaps every few dozen items
      if (i % 40 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 9);
      case (sel)
        4, 5: begin
          // shared factor, products kept inside 32 bits
          factor = $urandom_range(1, 65535);
          a = factor * $urandom_range(0, 65536);
          b = factor * $urandom_range(0, 65536);
        end
        6: begin
          // common power of two
          a = $urandom << $urandom_range(0, 31);
          b = $urandom << $urandom_range(0, 31);
        end
        7: begin
          // one operand zero
          a = $urandom;
          b = '0;
          if ($urandom_range(0, 1) == 1) begin
            b = a;
            a = '0;
          end
        end
        8: begin
          a = $urandom;
          b = a;
        end
        9: begin
          a = $urandom_range(0, 255);
          b = $urandom_range(0, 255);
        end
        default: begin
          a = $urandom;
          b = $urandom;
        end
      endcase
      send_item(a, b);
      // one full drain midway through
      if (i == count / 2) wait_for_drain();
    end
    burst_mode = 1'b0;
  endtask

  // result checker: every done cycle pops the oldest owed divisor
  always @(posedge clk) begin : check_divisor
    logic [FIELD_W-1:0] want;
    if (!rst) begin
      if ($isunknown(done)) begin
        report_mismatch("done is unknown");
      end else if (done) begin
        if (pending_divisors.size() == 0) begin
          report_mismatch($sformatf("divisor %0d with nothing owed", divisor));
        end else begin
          want = pending_divisors.pop_front();
          if (divisor !== want)
            report_mismatch($sformatf("divisor %0d, want %0d", divisor, want));
        end
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    start          = 1'b0;
    first_operand  = '0;
    second_operand = '0;
    error_count    = 0;
    burst_mode     = 1'b0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    test_edge_operands();
    wait_for_drain();
    test_random_operands(RAND_ITEMS);
    wait_for_drain();

    // catch any stray done after the last divisor
    repeat (LATENCY + 8) @(posedge clk);
    if (pending_divisors.size() != 0)
      report_mismatch($sformatf("%0d divisors never came", pending_divisors.size()));
    if (error_count == 0) begin
      $display("[subtractive_gcd] OK");
    end else begin
      $display("[subtractive_gcd] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #(400_000 * 2 * CLK_HALF);
    $display("[subtractive_gcd] ERROR");
    $finish;
  end

endmodule
